FILE: sv/ipcpd_pkg.sv
// shared types and constants for the inverse park/clarke pwm duty unit
// no dependencies
package ipcpd_pkg;

    typedef struct packed {
        logic signed [15:0] quad_voltage;
        logic        [15:0] elec_angle;
    } in_item_t;

    typedef struct packed {
        logic [12:0] duty_phase_a;
        logic [12:0] duty_phase_b;
        logic [12:0] duty_phase_c;
    } out_item_t;

    localparam int PWM_PERIOD_DEF = 4800;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'b1;
    localparam logic [15:0] SUPPLY_RESET = 16'd0;
    localparam logic [15:0] LIMIT_RESET  = 16'd3226;

    localparam int CORDIC_STEPS = 16;
    localparam int XW = 34;
    localparam logic signed [XW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
    localparam logic signed [XW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
        34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
        34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
        34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D
    };

endpackage

FILE: sv/ipcpd_cordic.sv
// pipelined cordic, one stage per step, cos and sin of the folded angle plus flip
// depends on ipcpd_pkg
module ipcpd_cordic #(
    parameter int ANGLE_BITS = ipcpd_pkg::ANGLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [15:0]              in_uq,
    input  logic        [15:0]              in_angle,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [ipcpd_pkg::XW-1:0] out_x,
    output logic signed [ipcpd_pkg::XW-1:0] out_y,
    output logic                            out_flip,
    output logic signed [15:0]              out_uq
);
    localparam int N  = ipcpd_pkg::CORDIC_STEPS;
    localparam int XW = ipcpd_pkg::XW;
    localparam logic [15:0] ANG_MASK =
        (ANGLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ANGLE_BITS) - 32'd1);

    logic [N:0]              v_reg;
    logic [N:0]              flip_reg;
    logic signed [XW-1:0]    x_reg [N+1];
    logic signed [XW-1:0]    y_reg [N+1];
    logic signed [XW-1:0]    z_reg [N+1];
    logic signed [15:0]      uq_reg [N+1];
    logic signed [XW-1:0]    x_next [N+1];
    logic signed [XW-1:0]    y_next [N+1];
    logic signed [XW-1:0]    z_next [N+1];
    logic [N+1:0]            adv;
    logic [31:0]             turn;
    logic                    flip_next;

    always_comb begin
        adv[N+1] = out_ready;
        for (int k = N; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end
    assign in_ready = adv[0];

    always_comb begin
        turn = 32'(in_angle & ANG_MASK) << (32 - ANGLE_BITS);
        flip_next = 1'b0;
        if (turn >= 32'h4000_0000 && turn < 32'hC000_0000) begin
            turn = turn - 32'h8000_0000;
            flip_next = 1'b1;
        end
        x_next[0] = ipcpd_pkg::CORDIC_START;
        y_next[0] = '0;
        z_next[0] = XW'(signed'(turn));
        for (int k = 0; k < N; k++) begin
            if (z_reg[k] >= 0) begin
                x_next[k+1] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] - ipcpd_pkg::ATAN_TURN[k];
            end else begin
                x_next[k+1] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] + ipcpd_pkg::ATAN_TURN[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k <= N; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            x_reg[0]    <= x_next[0];
            y_reg[0]    <= y_next[0];
            z_reg[0]    <= z_next[0];
            flip_reg[0] <= flip_next;
            uq_reg[0]   <= in_uq;
        end
        for (int k = 1; k <= N; k++) begin
            if (adv[k]) begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                flip_reg[k] <= flip_reg[k-1];
                uq_reg[k]   <= uq_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_x     = x_reg[N];
    assign out_y     = y_reg[N];
    assign out_flip  = flip_reg[N];
    assign out_uq    = uq_reg[N];

endmodule

FILE: sv/ipcpd_transform.sv
// inverse park and clarke, phase clamp and duty numerator, six register stages
// depends on ipcpd_pkg
module ipcpd_transform #(
    parameter int PWM_PERIOD = ipcpd_pkg::PWM_PERIOD_DEF,
    parameter int NW = 32 + $clog2(PWM_PERIOD + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [15:0]                     supply,
    input  logic [15:0]                     limit,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [ipcpd_pkg::XW-1:0] in_x,
    input  logic signed [ipcpd_pkg::XW-1:0] in_y,
    input  logic                            in_flip,
    input  logic signed [15:0]              in_uq,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0][NW-1:0]              out_num,
    output logic [2:0]                      out_sat,
    output logic                            out_zero
);
    localparam int XW = ipcpd_pkg::XW;
    localparam int PW = XW + 16;
    localparam int AW = 37;
    localparam int MW = AW + 32;
    localparam int UW = 40;
    localparam int NS = 6;

    logic [NS-1:0] v_reg;
    logic [NS:0]   adv;

    logic signed [PW-1:0] ps_reg, pc_reg;
    logic                 flip_reg;
    logic signed [AW-1:0] alpha2_reg, beta_reg;
    logic signed [MW-1:0] prod_reg;
    logic signed [AW-1:0] alpha3_reg;
    logic signed [UW-1:0] alpha4_reg, s3b_reg, ua_reg;
    logic [2:0][31:0]     u_reg;
    logic [2:0][NW-1:0]   num_reg;
    logic [2:0]           sat_reg;
    logic                 zero_reg;

    logic signed [PW:0]   sa_next, sb_next;
    logic signed [AW-1:0] alpha_next, beta_next;
    logic signed [MW-1:0] s3b_wide;
    logic signed [UW-1:0] half, ub_next, uc_next;
    logic [31:0]          sup_wide;

    function automatic logic [31:0] clamp_u(input logic signed [UW-1:0] u,
                                            input logic [15:0] lim);
        logic signed [UW-1:0] lim_s;
        lim_s = signed'(UW'({lim, 16'b0}));
        if (u < 0) begin
            return '0;
        end else if (u > lim_s) begin
            return {lim, 16'b0};
        end
        return u[31:0];
    endfunction

    always_comb begin
        adv[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end
    assign in_ready = adv[0];

    always_comb begin
        sa_next    = flip_reg ? (PW+1)'(ps_reg) : -(PW+1)'(ps_reg);
        sb_next    = flip_reg ? -(PW+1)'(pc_reg) : (PW+1)'(pc_reg);
        alpha_next = AW'((sa_next + (PW+1)'(8192)) >>> 14);
        beta_next  = AW'((sb_next + (PW+1)'(8192)) >>> 14);
        s3b_wide   = (prod_reg + (MW'(1) <<< 29)) >>> 30;
        half       = signed'(UW'({supply, 15'b0}));
        ub_next    = ((s3b_reg - alpha4_reg) >>> 1) + half;
        uc_next    = ((-(alpha4_reg + s3b_reg)) >>> 1) + half;
        sup_wide   = {supply, 16'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ps_reg   <= PW'(in_uq) * PW'(in_y);
            pc_reg   <= PW'(in_uq) * PW'(in_x);
            flip_reg <= in_flip;
        end
        if (adv[1]) begin
            alpha2_reg <= alpha_next;
            beta_reg   <= beta_next;
        end
        if (adv[2]) begin
            prod_reg   <= MW'(beta_reg) * MW'(ipcpd_pkg::SQRT3_Q30);
            alpha3_reg <= alpha2_reg;
        end
        if (adv[3]) begin
            s3b_reg    <= UW'(s3b_wide);
            alpha4_reg <= UW'(alpha3_reg);
            ua_reg     <= UW'(alpha3_reg) + signed'(UW'({supply, 15'b0}));
        end
        if (adv[4]) begin
            u_reg[0] <= clamp_u(ua_reg, limit);
            u_reg[1] <= clamp_u(ub_next, limit);
            u_reg[2] <= clamp_u(uc_next, limit);
        end
        if (adv[5]) begin
            for (int p = 0; p < 3; p++) begin
                num_reg[p] <= NW'(u_reg[p]) * NW'(PWM_PERIOD);
                sat_reg[p] <= u_reg[p] >= sup_wide;
            end
            zero_reg <= supply == 16'd0;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_num   = num_reg;
    assign out_sat   = sat_reg;
    assign out_zero  = zero_reg;

endmodule

FILE: sv/ipcpd_divider.sv
// three-lane pipelined restoring divider, one quotient bit per stage
// depends on ipcpd_pkg
module ipcpd_divider #(
    parameter int PWM_PERIOD = ipcpd_pkg::PWM_PERIOD_DEF,
    parameter int QW = $clog2(PWM_PERIOD + 1),
    parameter int NW = 32 + QW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          supply,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0][NW-1:0]   in_num,
    input  logic [2:0]           in_sat,
    input  logic                 in_zero,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ipcpd_pkg::out_item_t out_data
);
    logic [QW:0]            v_reg;
    logic [QW+1:0]          adv;
    logic [2:0][NW-1:0]     r_reg [QW+1];
    logic [2:0][QW-1:0]     q_reg [QW+1];
    logic [2:0]             sat_reg [QW+1];
    logic                   zero_reg [QW+1];
    logic [2:0][NW-1:0]     r_next [QW+1];
    logic [2:0][QW-1:0]     q_next [QW+1];
    logic [NW-1:0]          dshift;
    logic [2:0][12:0]       duty;

    always_comb begin
        adv[QW+1] = out_ready;
        for (int k = QW; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end
    assign in_ready = adv[0];

    always_comb begin
        r_next[0] = in_num;
        q_next[0] = '0;
        dshift    = '0;
        for (int k = 0; k < QW; k++) begin
            dshift      = NW'({supply, 16'b0}) << (QW - 1 - k);
            r_next[k+1] = r_reg[k];
            q_next[k+1] = q_reg[k];
            for (int p = 0; p < 3; p++) begin
                if (r_reg[k][p] >= dshift) begin
                    r_next[k+1][p]             = r_reg[k][p] - dshift;
                    q_next[k+1][p][QW - 1 - k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k <= QW; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            r_reg[0]    <= r_next[0];
            q_reg[0]    <= q_next[0];
            sat_reg[0]  <= in_sat;
            zero_reg[0] <= in_zero;
        end
        for (int k = 1; k <= QW; k++) begin
            if (adv[k]) begin
                r_reg[k]    <= r_next[k];
                q_reg[k]    <= q_next[k];
                sat_reg[k]  <= sat_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            if (zero_reg[QW]) begin
                duty[p] = '0;
            end else if (sat_reg[QW][p]) begin
                duty[p] = 13'(PWM_PERIOD);
            end else begin
                duty[p] = 13'(q_reg[QW][p]);
            end
        end
    end

    assign out_valid             = v_reg[QW];
    assign out_data.duty_phase_a = duty[0];
    assign out_data.duty_phase_b = duty[1];
    assign out_data.duty_phase_c = duty[2];

endmodule

FILE: sv/inverse_park_clarke_pwm_duty_unit.sv
// inverse park/clarke to three-phase pwm compare counts, top level
// throughput one transfer per cycle while m_ready stays high, every stage holds its own valid bit
// reset clears all valid bits, supply to 0 and phase limit to 3226
// depends on ipcpd_pkg, ipcpd_cordic, ipcpd_transform, ipcpd_divider
module inverse_park_clarke_pwm_duty_unit #(
    parameter int PWM_PERIOD = ipcpd_pkg::PWM_PERIOD_DEF,
    parameter int ANGLE_BITS = ipcpd_pkg::ANGLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ipcpd_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ipcpd_pkg::out_item_t                m_data,
    input  logic                                cfg_we,
    input  logic [ipcpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);
    localparam int QW = $clog2(PWM_PERIOD + 1);
    localparam int NW = 32 + QW;

    logic [15:0] supply_reg, limit_reg;

    logic                            c_valid, c_ready, c_flip;
    logic signed [ipcpd_pkg::XW-1:0] c_x, c_y;
    logic signed [15:0]              c_uq;
    logic                            t_valid, t_ready, t_zero;
    logic [2:0][NW-1:0]              t_num;
    logic [2:0]                      t_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            supply_reg <= ipcpd_pkg::SUPPLY_RESET;
            limit_reg  <= ipcpd_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ipcpd_pkg::REG_SUPPLY: supply_reg <= cfg_data;
                ipcpd_pkg::REG_LIMIT:  limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    ipcpd_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_uq     (s_data.quad_voltage),
        .in_angle  (s_data.elec_angle),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_x     (c_x),
        .out_y     (c_y),
        .out_flip  (c_flip),
        .out_uq    (c_uq)
    );

    ipcpd_transform #(.PWM_PERIOD(PWM_PERIOD), .NW(NW)) u_transform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .supply    (supply_reg),
        .limit     (limit_reg),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_x      (c_x),
        .in_y      (c_y),
        .in_flip   (c_flip),
        .in_uq     (c_uq),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_num   (t_num),
        .out_sat   (t_sat),
        .out_zero  (t_zero)
    );

    ipcpd_divider #(.PWM_PERIOD(PWM_PERIOD), .QW(QW), .NW(NW)) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .supply    (supply_reg),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_num    (t_num),
        .in_sat    (t_sat),
        .in_zero   (t_zero),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

FILE: bench/tb.sv
// testbench for inverse_park_clarke_pwm_duty_unit: directed and random angle/voltage items
// with bursty input, stalling output and a long output hold-off; duties predicted in fixed point
// depends on ipcpd_pkg and the block's rtl
module tb;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ipcpd_pkg::in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ipcpd_pkg::out_item_t m_data;
    logic      cfg_we = 1'b0;
    logic [ipcpd_pkg::CFG_IDX_W-1:0] cfg_index = ipcpd_pkg::REG_SUPPLY;
    logic [15:0] cfg_data = '0;

    localparam int LATENCY = 60;
    localparam int CYCLE_LIMIT = 400000;

    ipcpd_pkg::out_item_t duty_queue[$];
    logic [15:0] supply_reg;
    logic [15:0] limit_reg;
    int errors = 0;
    int cycles = 0;
    int hold_off = 0;
    bit stall_en = 1'b1;

    inverse_park_clarke_pwm_duty_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [12:0] phase_duty(longint u);
        longint lim;
        longint sup;
        lim = longint'(limit_reg) << 16;
        sup = longint'(supply_reg) << 16;
        if (u < 0) u = 0;
        if (u > lim) u = lim;
        if (sup == 0) return '0;
        if (u >= sup) return 13'(ipcpd_pkg::PWM_PERIOD_DEF);
        return 13'((u * ipcpd_pkg::PWM_PERIOD_DEF) / sup);
    endfunction

    function automatic ipcpd_pkg::out_item_t predict_duty(ipcpd_pkg::in_item_t it);
        logic [31:0] turn;
        bit flip;
        longint z, x, y, dx, dy, uq, alpha, beta, s3b, half;
        ipcpd_pkg::out_item_t r;
        turn = {it.elec_angle, 16'h0000};
        flip = 1'b0;
        if (turn >= 32'h4000_0000 && turn < 32'hC000_0000) begin
            turn = turn - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(turn));
        x = ipcpd_pkg::CORDIC_START;
        y = 0;
        for (int i = 0; i < ipcpd_pkg::CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ipcpd_pkg::ATAN_TURN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ipcpd_pkg::ATAN_TURN[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        uq = longint'(it.quad_voltage);
        alpha = floor_shr(-uq * y + 8192, 14);
        beta = floor_shr(uq * x + 8192, 14);
        s3b = floor_shr(beta * longint'(ipcpd_pkg::SQRT3_Q30) + (longint'(1) << 29), 30);
        half = longint'(supply_reg) << 15;
        r.duty_phase_a = phase_duty(alpha + half);
        r.duty_phase_b = phase_duty(floor_shr(s3b - alpha, 1) + half);
        r.duty_phase_c = phase_duty(floor_shr(-(alpha + s3b), 1) + half);
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        $display("error: %s got %0d expected %0d", what, got, want);
    endtask

    // receiver: random stall pattern unless stall_en is clear, long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        ipcpd_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_queue.size() == 0) begin
                report("unexpected transfer", 0, 0);
            end else begin
                want = duty_queue.pop_front();
                if (m_data.duty_phase_a !== want.duty_phase_a)
                    report("duty a", m_data.duty_phase_a, want.duty_phase_a);
                if (m_data.duty_phase_b !== want.duty_phase_b)
                    report("duty b", m_data.duty_phase_b, want.duty_phase_b);
                if (m_data.duty_phase_c !== want.duty_phase_c)
                    report("duty c", m_data.duty_phase_c, want.duty_phase_c);
            end
        end
    end

    int burst_left = 0;

    task automatic send_item(logic signed [15:0] volts, logic [15:0] angle);
        ipcpd_pkg::in_item_t it;
        it.quad_voltage = volts;
        it.elec_angle = angle;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= it;
        duty_queue.push_back(predict_duty(it));
        do @(posedge aclk); while (!s_ready);
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic drain();
        if (burst_left != 0) begin
            s_valid <= 1'b0;
            burst_left = 0;
        end
        while (duty_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ipcpd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        if (idx == ipcpd_pkg::REG_SUPPLY) supply_reg = val;
        else limit_reg = val;
    endtask

    task automatic set_config(logic [15:0] sup, logic [15:0] lim);
        drain();
        write_reg(ipcpd_pkg::REG_SUPPLY, sup);
        write_reg(ipcpd_pkg::REG_LIMIT, lim);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_item(16'sd2000, 16'h1234);
        send_item(-16'sd2000, 16'h9000);
    endtask

    task automatic test_directed();
        logic signed [15:0] v[6] = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd1536};
        logic [15:0] a[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF};
        set_config(16'd3072, 16'd3226);
        for (int i = 0; i < 6; i++) send_item(v[i], a[i]);
        set_config(16'd3072, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_item(v[5 - i], a[i]);
        set_config(16'hFFFF, 16'd0);
        send_item(16'sh7FFF, 16'h2000);
        send_item(-16'sh8000, 16'h6000);
        set_config(16'hFFFF, 16'hFFFF);
        send_item(16'sh7FFF, 16'hA000);
        send_item(-16'sh8000, 16'hE000);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_config(16'd3072, 16'd3226);
                1: set_config(16'($urandom), 16'($urandom));
                2: set_config(16'd1, 16'd1);
                3: set_config(16'd0, 16'($urandom));
                default: set_config(16'($urandom_range(256, 12800)), 16'hFFFF);
            endcase
            stall_en = (ph != 2);
            for (int n = 0; n < 200; n++) begin
                if (ph == 1 && n == 50) hold_off = 300;
                send_item(16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        supply_reg = ipcpd_pkg::SUPPLY_RESET;
        limit_reg = ipcpd_pkg::LIMIT_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_directed();
        test_random();
        drain();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
